### sv/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

   localparam int DTQ_NUM_TIMERS = 16;
   localparam int OP_W           = 2;
   localparam int SLOT_W         = 4;
   localparam int TIME_W         = 32;
   localparam int TAG_W          = 8;

   typedef enum logic [OP_W-1:0] {
      OP_ARM    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_EXPIRE = 2'd3
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch the accepted item
      logic apply;       // table / alarm / flag update of the operation
      logic scan_clear;  // restart the earliest-deadline scan
      logic scan_step;   // visit one slot
      logic fire;        // emit the earliest slot as fired and retire it
      logic finish;      // run the closing check and emit the last result
   } dtq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;   // the slot being visited is the last one
      logic due;         // expire op and earliest active deadline <= now
      logic out_free;    // output register can take a result this cycle
   } dtq_status_type;

endpackage

### sv/dtq_ctrl.sv
// Sequencer for the deadline timer queue: accept, apply, scan, emit.
module dtq_ctrl
   import dtq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  dtq_status_type status,
   output dtq_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      stall_ff;
   logic      stall_in;

   always_comb begin
      state_in = state_ff;
      stall_in = stall_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.load = 1'b1;
               state_in = ST_APPLY;
               stall_in = 1'b1;
            end
         end
         ST_APPLY: begin
            cmd.apply      = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (status.due) begin
                  cmd.fire       = 1'b1;
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
                  stall_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            stall_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

### sv/dtq_datapath.sv
// Slot table, earliest-deadline scanner, alarm state and output register.
module dtq_datapath
   import dtq_pkg::*;
#(
   parameter int NUM_TIMERS = DTQ_NUM_TIMERS
)(
   input  logic                clock,
   input  logic                reset,
   input  dtq_cmd_type         cmd,
   output dtq_status_type      status,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SLOT_W-1:0]   req_timer_slot,
   input  logic [TIME_W-1:0]   req_deadline,
   input  logic [TAG_W-1:0]    req_timer_ref,
   input  logic [TIME_W-1:0]   req_now,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_fired,
   output logic [SLOT_W-1:0]   rsp_fired_slot,
   output logic [TAG_W-1:0]    rsp_fired_ref,
   output logic                rsp_alarm_set,
   output logic [TIME_W-1:0]   rsp_alarm_delta,
   output logic                rsp_expire_pending,
   output logic                rsp_last
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // slot table
   logic [TIME_W-1:0]     dl_mem [NUM_TIMERS];
   logic [TAG_W-1:0]      tag_mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] active_ff;

   // latched item
   op_type              op_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [TIME_W-1:0]   dl_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [TIME_W-1:0]   now_ff;

   // scanner
   logic [IDX_W-1:0]    cnt_ff;
   logic [IDX_W-1:0]    best_ff;
   logic [TIME_W-1:0]   best_dl_ff;
   logic                found_ff;

   // registered table read, compared in the next cycle
   logic                rd_vld_ff;
   logic                rd_act_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [TIME_W-1:0]   rd_dl_ff;

   logic [TIME_W-1:0]   alarm_ff;
   logic                flag_ff;

   // output register
   logic                out_valid_ff;
   logic                out_fired_ff;
   logic [SLOT_W-1:0]   out_slot_ff;
   logic [TAG_W-1:0]    out_tag_ff;
   logic                out_set_ff;
   logic [TIME_W-1:0]   out_delta_ff;
   logic                out_pend_ff;
   logic                out_last_ff;

   logic                in_range;
   logic [IDX_W-1:0]    slot_idx;
   logic                take;
   logic                due_now;
   logic                alarm_zero;
   logic                earlier;
   logic                guard_ok;
   logic                flag_set;
   logic                prog;
   logic                out_free;

   assign in_range   = 32'(slot_ff) < 32'(NUM_TIMERS);
   assign slot_idx   = IDX_W'(slot_ff);
   assign take       = rd_vld_ff && rd_act_ff && (!found_ff || rd_dl_ff < best_dl_ff);
   assign due_now    = found_ff && (best_dl_ff <= now_ff);
   assign alarm_zero = (alarm_ff == '0);
   assign earlier    = best_dl_ff < alarm_ff;
   // an arm that lands behind the programmed alarm leaves flag and alarm alone
   assign guard_ok   = !((op_ff == OP_ARM) && in_range) || alarm_zero || earlier;
   assign flag_set   = due_now && guard_ok;
   assign prog       = found_ff && !due_now && (alarm_zero || earlier);
   assign out_free   = !out_valid_ff || !rsp_stall;

   assign status.scan_done = rd_vld_ff && (rd_idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign status.due       = (op_ff == OP_EXPIRE) && due_now;
   assign status.out_free  = out_free;

   // item latch, table payload and scan read port
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_operation);
         slot_ff <= req_timer_slot;
         dl_ff   <= req_deadline;
         tag_ff  <= req_timer_ref;
         now_ff  <= req_now;
      end
      if (cmd.apply && op_ff == OP_ARM && in_range) begin
         dl_mem[slot_idx]  <= dl_ff;
         tag_mem[slot_idx] <= tag_ff;
      end
      if (cmd.scan_step) begin
         rd_dl_ff  <= dl_mem[cnt_ff];
         rd_act_ff <= active_ff[cnt_ff];
         rd_idx_ff <= cnt_ff;
      end
   end

   // control state of the table, scanner and alarm
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         alarm_ff  <= '0;
         flag_ff   <= 1'b0;
         found_ff  <= 1'b0;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.apply) begin
            unique case (op_ff)
               OP_ARM: begin
                  if (in_range) active_ff[slot_idx] <= 1'b1;
               end
               OP_CANCEL: begin
                  if (in_range) active_ff[slot_idx] <= 1'b0;
               end
               OP_TICK:   alarm_ff <= '0;
               OP_EXPIRE: flag_ff  <= 1'b0;
               default: ;
            endcase
         end
         if (cmd.fire) begin
            active_ff[best_ff] <= 1'b0;
         end
         if (cmd.finish) begin
            if (flag_set) flag_ff  <= 1'b1;
            if (prog)     alarm_ff <= best_dl_ff;
         end
         if (cmd.scan_clear) begin
            cnt_ff    <= '0;
            found_ff  <= 1'b0;
            rd_vld_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            cnt_ff    <= cnt_ff + IDX_W'(1);
            rd_vld_ff <= 1'b1;
            if (take) found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && take) begin
         best_ff    <= rd_idx_ff;
         best_dl_ff <= rd_dl_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.fire || cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         out_fired_ff <= 1'b1;
         out_slot_ff  <= SLOT_W'(best_ff);
         out_tag_ff   <= tag_mem[best_ff];
         out_set_ff   <= 1'b0;
         out_delta_ff <= '0;
         out_pend_ff  <= 1'b0;
         out_last_ff  <= 1'b0;
      end else if (cmd.finish) begin
         out_fired_ff <= 1'b0;
         out_slot_ff  <= '0;
         out_tag_ff   <= '0;
         out_set_ff   <= prog;
         out_delta_ff <= prog ? (best_dl_ff - now_ff) : '0;
         out_pend_ff  <= flag_ff || flag_set;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_fired          = out_fired_ff;
   assign rsp_fired_slot     = out_slot_ff;
   assign rsp_fired_ref      = out_tag_ff;
   assign rsp_alarm_set      = out_set_ff;
   assign rsp_alarm_delta    = out_delta_ff;
   assign rsp_expire_pending = out_pend_ff;
   assign rsp_last           = out_last_ff;

   a_fire_retires: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> !active_ff[$past(best_ff)])
      else $error("fired slot still active");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.fire || cmd.finish) |-> out_free)
      else $error("result emitted into a busy output register");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (out_valid_ff && out_last_ff && !out_fired_ff))
      else $error("closing result not marked last");

   a_prog_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && prog) |=> (alarm_ff != '0))
      else $error("programmed alarm reads as none");

endmodule

### sv/deadline_timer_queue_top.sv
// Top level of the deadline timer queue: sequencer plus slot-table datapath.
//
//  channel | ports  | direction | moves
//  --------+--------+-----------+-----------------------------------------
//  request | req_*  | in        | one operation item (arm/cancel/tick/expire)
//  result  | rsp_*  | out       | fired items, then one closing item (last)
//
// Sequence: an item is accepted, applied, scanned (one registered table
//   read per slot, then a compare of the last slot) and emitted; every timer
//   fired by an expire reruns the scan before the next result.
// The next item is taken once the closing result sits in the output register.
// Reset: synchronous, clears active marks, alarm, pending flag and handshakes;
//   no clearing pass is needed.
// A stalled result holds the output register and the sequencer waits in emit.
module deadline_timer_queue_top
   import dtq_pkg::*;
#(
   parameter int NUM_TIMERS = DTQ_NUM_TIMERS
)(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SLOT_W-1:0]   req_timer_slot,
   input  logic [TIME_W-1:0]   req_deadline,
   input  logic [TAG_W-1:0]    req_timer_ref,
   input  logic [TIME_W-1:0]   req_now,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_fired,
   output logic [SLOT_W-1:0]   rsp_fired_slot,
   output logic [TAG_W-1:0]    rsp_fired_ref,
   output logic                rsp_alarm_set,
   output logic [TIME_W-1:0]   rsp_alarm_delta,
   output logic                rsp_expire_pending,
   output logic                rsp_last
);

   dtq_cmd_type    cmd;
   dtq_status_type status;

   // sequencer: owns req_stall, steps the datapath through each item
   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: slot table, scanner, alarm/flag state, result register
   dtq_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_timer_slot     (req_timer_slot),
      .req_deadline       (req_deadline),
      .req_timer_ref      (req_timer_ref),
      .req_now            (req_now),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fired          (rsp_fired),
      .rsp_fired_slot     (rsp_fired_slot),
      .rsp_fired_ref      (rsp_fired_ref),
      .rsp_alarm_set      (rsp_alarm_set),
      .rsp_alarm_delta    (rsp_alarm_delta),
      .rsp_expire_pending (rsp_expire_pending),
      .rsp_last           (rsp_last)
   );

endmodule
